>>> design/akf_pkg.sv
// Shared types, register codes and saturation helpers for the angle Kalman filter.
package akf_pkg;

   localparam int WIDE_W    = 50;
   localparam int CSR_IDX_W = 2;
   localparam int NOISE_W   = 24;
   localparam int DIV_STEPS = 31;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ANGLE_NOISE   = 2'd0,
      REG_BIAS_NOISE    = 2'd1,
      REG_MEASURE_NOISE = 2'd2
   } csr_reg_type;

   localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 24'd16777;
   localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 24'd50332;
   localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd503316;

   localparam wide_type S32_MAX = 50'sd2147483647;
   localparam wide_type S32_MIN = -50'sd2147483648;
   localparam wide_type S40_MAX = 50'sd549755813887;
   localparam wide_type S40_MIN = -50'sd549755813888;

   // multiply-accumulate control, travels one stage with the product
   typedef struct packed {
      logic issue;
      logic clear;
      logic shift;
      logic rnd24;
   } mac_ctl_type;

   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7fffffff;
      else if (v < S32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [39:0] sat40(input wide_type v);
      logic signed [39:0] r;
      if (v > S40_MAX) r = 40'sh7fffffffff;
      else if (v < S40_MIN) r = 40'sh8000000000;
      else r = v[39:0];
      return r;
   endfunction

endpackage

>>> design/akf_mac.sv
// Shared 33x33 signed multiplier with registered product and rounding accumulator.
module akf_mac
   import akf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mac_ctl_type         ctl,
   input  logic signed [32:0]  op_a,
   input  logic signed [32:0]  op_b,
   output logic signed [71:0]  acc
);

   logic signed [65:0] prod_ff, prod_in;
   mac_ctl_type        ctl_ff;
   logic signed [71:0] acc_ff, acc_in;
   logic signed [71:0] base;
   logic signed [71:0] addend;

   assign prod_in = op_a * op_b;

   always_comb begin
      // clearing loads half an LSB of the final shift
      base   = ctl_ff.clear ? (ctl_ff.rnd24 ? 72'sd8388608 : 72'sd32768) : acc_ff;
      addend = ctl_ff.shift ? (72'(prod_ff) <<< 24) : 72'(prod_ff);
      acc_in = ctl_ff.issue ? base + addend : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> design/akf_div.sv
// Restoring gain divider: sat32(num*2^24/den), 0 if den<1, one quotient bit per cycle.
module akf_div
   import akf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [39:0]  num,
   input  logic signed [40:0]  den,
   output logic                busy,
   output logic                done,
   output logic signed [31:0]  quot
);

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type         state_ff, state_in;
   logic [40:0]        rem_ff, rem_in;
   logic [30:0]        low_ff, low_in;
   logic [30:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [39:0]        den_ff, den_in;
   logic               done_ff, done_in;
   logic signed [31:0] quot_ff, quot_in;

   logic [39:0] mag;
   logic        ovf;
   logic [41:0] trial;
   logic [41:0] den_x;
   logic        qbit;

   always_comb begin
      mag   = num[39] ? 40'(-num) : 40'(num);
      ovf   = {7'b0, mag} >= {den[39:0], 7'b0};
      trial = {rem_ff, low_ff[30]};
      den_x = {2'b0, den_ff};
      qbit  = trial >= den_x;

      state_in = state_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               if (den <= 41'sd0) begin
                  quot_in = '0;
                  done_in = 1'b1;
               end else if (ovf) begin
                  quot_in = num[39] ? 32'sh80000000 : 32'sh7fffffff;
                  done_in = 1'b1;
               end else begin
                  // quotient fits 31 bits, so the top part is already below den
                  rem_in   = {8'b0, mag[39:7]};
                  low_in   = {mag[6:0], 24'b0};
                  q_in     = '0;
                  cnt_in   = '0;
                  neg_in   = num[39];
                  den_in   = den[39:0];
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            rem_in = qbit ? 41'(trial - den_x) : trial[40:0];
            low_in = {low_ff[29:0], 1'b0};
            q_in   = {q_ff[29:0], qbit};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               quot_in  = neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = (state_ff == D_RUN);
   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> design/angle_kalman_filter_core.sv
// Top level: sequencer around the shared multiplier and divider of the angle Kalman filter.
//
// Usage:
//  - req_ channel takes one sample transaction: accelerometer angle, gyro rate, time step.
//  - rsp_ channel returns one transaction per sample: corrected angle, unbiased rate, bias.
//  - csr_ channel writes the three noise registers (index 0 angle, 1 bias, 2 measurement);
//    csr_ready is always high, writes belong between samples.
//  - req_tready is high only while the sequencer is idle; the time from acceptance to the result
//    register is set mostly by the two 31-step gain divisions, so a new sample is taken only
//    after the previous one has been loaded into the result register.
//    A division that saturates or meets a non-positive innovation variance finishes
//    without running its division steps.
//  - All products go through one 33x33 multiplier with a registered product and accumulator; wide operands
//    are split into a low 24-bit part and a signed high part and accumulated.
//  - The result sits in an output register; the next sample is accepted while it waits.
//    If rsp_tready stays low the sequencer holds in its final step until the register frees.
//  - Reset clears angle, bias and covariance and restores the default noise values.
module angle_kalman_filter_core
   import akf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,   // measured_angle, measured_rate, time_step
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,   // angle_estimate, rate_estimate, bias_estimate
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [NOISE_W-1:0]   csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_RATE, ST_M_ANG, ST_WAIT, ST_U_ANG, ST_M_A0, ST_M_A1, ST_U_A,
      ST_INNER, ST_M_I0, ST_M_I1, ST_U_I, ST_M_BN, ST_U_BN, ST_D_START, ST_D_WAIT,
      ST_Y, ST_M_K0Y, ST_U_K0Y, ST_M_K1Y, ST_U_K1Y, ST_G_LO, ST_G_HI, ST_G_UPD, ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   state_type          after_ff, after_in;
   logic [NOISE_W-1:0] an_ff, an_in, bn_ff, bn_in, mn_ff, mn_in;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [39:0] p_ff [4];
   logic signed [39:0] p_in [4];
   logic signed [31:0] mang_ff, mang_in, mrate_ff, mrate_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] rate_ff, rate_in;
   logic signed [39:0] a_ff, a_in;
   logic signed [41:0] inner_ff, inner_in;
   logic signed [40:0] s_ff, s_in;
   logic signed [31:0] k_ff [2];
   logic signed [31:0] k_in [2];
   logic signed [31:0] y_ff, y_in;
   logic               div_sel_ff, div_sel_in;
   logic [1:0]         gcnt_ff, gcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   mac_ctl_type        mac_ctl;
   logic signed [32:0] op_a, op_b;
   logic signed [71:0] acc;
   wide_type           acc16, acc24;

   logic               div_start, div_busy, div_done;
   logic signed [39:0] div_num;
   logic signed [31:0] div_quot;

   logic [1:0]         gidx;
   logic signed [39:0] g_src, g_dst;
   logic signed [31:0] g_k;

   akf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   akf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (s_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign acc16 = acc[65:16];
   assign acc24 = {{2{acc[71]}}, acc[71:24]};

   // covariance update order P10, P11, P00, P01 keeps P00 and P01 intact for the gains
   assign gidx  = gcnt_ff ^ 2'b10;
   assign g_k   = k_ff[gidx[1]];
   assign g_src = gidx[0] ? p_ff[1] : p_ff[0];
   assign g_dst = p_ff[gidx];

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      mn_in        = mn_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      p_in         = p_ff;
      mang_in      = mang_ff;
      mrate_in     = mrate_ff;
      dt_in        = dt_ff;
      rate_in      = rate_ff;
      a_in         = a_ff;
      inner_in     = inner_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      y_in         = y_ff;
      div_sel_in   = div_sel_ff;
      gcnt_in      = gcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mac_ctl      = '0;
      op_a         = '0;
      op_b         = '0;
      div_start    = 1'b0;
      div_num      = div_sel_ff ? p_ff[2] : p_ff[0];

      if (csr_valid) begin
         unique case (csr_index)
            REG_ANGLE_NOISE:   an_in = csr_data;
            REG_BIAS_NOISE:    bn_in = csr_data;
            REG_MEASURE_NOISE: mn_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mang_in  = req_tdata[31:0];
               mrate_in = req_tdata[63:32];
               dt_in    = req_tdata[79:64];
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            rate_in  = sat32(wide_type'(mrate_ff) - wide_type'(bias_ff));
            state_in = ST_M_ANG;
         end
         ST_M_ANG: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b0};
            op_a     = {rate_ff[31], rate_ff};
            op_b     = {17'b0, dt_ff};
            after_in = ST_U_ANG;
            state_in = ST_WAIT;
         end
         ST_WAIT: state_in = after_ff;
         ST_U_ANG: begin
            angle_in = sat32(wide_type'(angle_ff) + acc16);
            state_in = ST_M_A0;
         end
         ST_M_A0: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b0};
            op_a     = {17'b0, dt_ff};
            op_b     = {9'b0, p_ff[3][23:0]};
            state_in = ST_M_A1;
         end
         ST_M_A1: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b0, shift: 1'b1, rnd24: 1'b0};
            op_a     = {17'b0, dt_ff};
            op_b     = {{17{p_ff[3][39]}}, p_ff[3][39:24]};
            after_in = ST_U_A;
            state_in = ST_WAIT;
         end
         ST_U_A: begin
            a_in     = acc16[39:0];
            state_in = ST_INNER;
         end
         ST_INNER: begin
            inner_in = 42'(wide_type'(a_ff) - wide_type'(p_ff[1]) - wide_type'(p_ff[2])
                           + wide_type'({26'b0, an_ff}));
            state_in = ST_M_I0;
         end
         ST_M_I0: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b0};
            op_a     = {17'b0, dt_ff};
            op_b     = {9'b0, inner_ff[23:0]};
            state_in = ST_M_I1;
         end
         ST_M_I1: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b0, shift: 1'b1, rnd24: 1'b0};
            op_a     = {17'b0, dt_ff};
            op_b     = {{15{inner_ff[41]}}, inner_ff[41:24]};
            after_in = ST_U_I;
            state_in = ST_WAIT;
         end
         ST_U_I: begin
            p_in[0]  = sat40(wide_type'(p_ff[0]) + acc16);
            p_in[1]  = sat40(wide_type'(p_ff[1]) - wide_type'(a_ff));
            p_in[2]  = sat40(wide_type'(p_ff[2]) - wide_type'(a_ff));
            state_in = ST_M_BN;
         end
         ST_M_BN: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b0};
            op_a     = {9'b0, bn_ff};
            op_b     = {17'b0, dt_ff};
            after_in = ST_U_BN;
            state_in = ST_WAIT;
         end
         ST_U_BN: begin
            p_in[3]    = sat40(wide_type'(p_ff[3]) + acc16);
            s_in       = {p_ff[0][39], p_ff[0]} + {17'b0, mn_ff};
            div_sel_in = 1'b0;
            state_in   = ST_D_START;
         end
         ST_D_START: begin
            div_start = 1'b1;
            state_in  = ST_D_WAIT;
         end
         ST_D_WAIT: begin
            if (div_done) begin
               k_in[div_sel_ff] = div_quot;
               if (div_sel_ff) begin
                  state_in = ST_Y;
               end else begin
                  div_sel_in = 1'b1;
                  state_in   = ST_D_START;
               end
            end
         end
         ST_Y: begin
            y_in     = sat32(wide_type'(mang_ff) - wide_type'(angle_ff));
            state_in = ST_M_K0Y;
         end
         ST_M_K0Y: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b1};
            op_a     = {k_ff[0][31], k_ff[0]};
            op_b     = {y_ff[31], y_ff};
            after_in = ST_U_K0Y;
            state_in = ST_WAIT;
         end
         ST_U_K0Y: begin
            angle_in = sat32(wide_type'(angle_ff) + acc24);
            state_in = ST_M_K1Y;
         end
         ST_M_K1Y: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b1};
            op_a     = {k_ff[1][31], k_ff[1]};
            op_b     = {y_ff[31], y_ff};
            after_in = ST_U_K1Y;
            state_in = ST_WAIT;
         end
         ST_U_K1Y: begin
            bias_in  = sat32(wide_type'(bias_ff) + acc24);
            gcnt_in  = '0;
            state_in = ST_G_LO;
         end
         ST_G_LO: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b1, shift: 1'b0, rnd24: 1'b1};
            op_a     = {g_k[31], g_k};
            op_b     = {9'b0, g_src[23:0]};
            state_in = ST_G_HI;
         end
         ST_G_HI: begin
            mac_ctl  = '{issue: 1'b1, clear: 1'b0, shift: 1'b1, rnd24: 1'b1};
            op_a     = {g_k[31], g_k};
            op_b     = {{17{g_src[39]}}, g_src[39:24]};
            after_in = ST_G_UPD;
            state_in = ST_WAIT;
         end
         ST_G_UPD: begin
            p_in[gidx] = sat40(wide_type'(g_dst) - acc24);
            gcnt_in    = gcnt_ff + 2'd1;
            state_in   = (gcnt_ff == 2'd3) ? ST_OUT : ST_G_LO;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {bias_ff, rate_ff, angle_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         an_ff        <= ANGLE_NOISE_RST;
         bn_ff        <= BIAS_NOISE_RST;
         mn_ff        <= MEASURE_NOISE_RST;
         angle_ff     <= '0;
         bias_ff      <= '0;
         p_ff         <= '{default: '0};
         div_sel_ff   <= 1'b0;
         gcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         an_ff        <= an_in;
         bn_ff        <= bn_in;
         mn_ff        <= mn_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p_ff         <= p_in;
         div_sel_ff   <= div_sel_in;
         gcnt_ff      <= gcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mang_ff     <= mang_in;
      mrate_ff    <= mrate_in;
      dt_ff       <= dt_in;
      rate_ff     <= rate_in;
      a_ff        <= a_in;
      inner_ff    <= inner_in;
      s_ff        <= s_in;
      k_ff        <= k_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer ready straight after taking a sample");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_D_WAIT))
      else $error("divider finished outside its wait step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_OUT))
      else $error("result register loaded outside the output step");

endmodule

>>> dv/angle_kalman_filter_core_test.sv
// Self-checking testbench for the angle Kalman filter core: predicts each sample result.
module angle_kalman_filter_core_test
   import akf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] bias_estimate;
      logic signed [31:0] rate_estimate;
      logic signed [31:0] angle_estimate;
   } estimate_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_ANGLE_NOISE;
   logic [NOISE_W-1:0]   csr_data = '0;

   angle_kalman_filter_core dut (.*);

   initial forever #1 clock = ~clock;

   // predictor state
   longint angle_noise_q, bias_noise_q, measure_noise_q;
   longint angle_q, bias_q;
   longint cov_q [4];
   estimate_type expected_estimates [$];
   int     mismatch_count = 0;
   bit     hold_off = 1'b0;

   function automatic longint sat_to(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // >>> on longint floors
   function automatic longint round_down(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint gain_times(longint k, longint p);
      longint hi, lo;
      hi = p >>> 24;
      lo = p - (hi << 24);
      return k * hi + round_down(k * lo, 24);
   endfunction

   task automatic reset_predictor();
      angle_noise_q = ANGLE_NOISE_RST;
      bias_noise_q = BIAS_NOISE_RST;
      measure_noise_q = MEASURE_NOISE_RST;
      angle_q = 0;
      bias_q = 0;
      foreach (cov_q[i]) cov_q[i] = 0;
   endtask

   function automatic estimate_type filter_sample(logic signed [31:0] meas_angle,
                                                  logic signed [31:0] meas_rate,
                                                  logic [15:0] step);
      longint dt, rate, a, inner, p00, p01, p10, p11, s, k0, k1, y;
      estimate_type e;
      dt = step;
      rate = sat_to(longint'(meas_rate) - bias_q, 32);
      angle_q = sat_to(angle_q + round_down(dt * rate, 16), 32);
      p00 = cov_q[0]; p01 = cov_q[1]; p10 = cov_q[2]; p11 = cov_q[3];
      a = round_down(dt * p11, 16);
      inner = a - p01 - p10 + angle_noise_q;
      p00 = sat_to(p00 + round_down(dt * inner, 16), 40);
      p01 = sat_to(p01 - a, 40);
      p10 = sat_to(p10 - a, 40);
      p11 = sat_to(p11 + round_down(bias_noise_q * dt, 16), 40);
      s = p00 + measure_noise_q;
      if (s > 0) begin
         k0 = sat_to((p00 * (longint'(1) << 24)) / s, 32);
         k1 = sat_to((p10 * (longint'(1) << 24)) / s, 32);
      end else begin
         k0 = 0;
         k1 = 0;
      end
      y = sat_to(longint'(meas_angle) - angle_q, 32);
      angle_q = sat_to(angle_q + round_down(k0 * y, 24), 32);
      bias_q = sat_to(bias_q + round_down(k1 * y, 24), 32);
      cov_q[0] = sat_to(p00 - gain_times(k0, p00), 40);
      cov_q[1] = sat_to(p01 - gain_times(k0, p01), 40);
      cov_q[2] = sat_to(p10 - gain_times(k1, p00), 40);
      cov_q[3] = sat_to(p11 - gain_times(k1, p01), 40);
      e.angle_estimate = angle_q[31:0];
      e.rate_estimate = rate[31:0];
      e.bias_estimate = bias_q[31:0];
      return e;
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
             ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
   endfunction

   task automatic send_sample(logic signed [31:0] ang, logic signed [31:0] rt,
                              logic [15:0] step, bit gaps = 1'b1);
      int gap;
      gap = gaps ? short_gap() : 0;
      @(negedge clock);
      repeat (gap) @(negedge clock);
      req_tdata <= {step, rt, ang};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_estimates.push_back(filter_sample(ang, rt, step));
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_noise(csr_reg_type idx, logic [NOISE_W-1:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ANGLE_NOISE:   angle_noise_q = val;
         REG_BIAS_NOISE:    bias_noise_q = val;
         default:           measure_noise_q = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_estimates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_estimates.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp angle %0d rate %0d bias %0d, got %0d %0d %0d",
                           want.angle_estimate, want.rate_estimate, want.bias_estimate,
                           got.angle_estimate, got.rate_estimate, got.bias_estimate);
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 9) < 3) rsp_tready <= 1'b0;
      else rsp_tready <= 1'b1;
   end

   task automatic test_extremes();
      send_sample(0, 0, 0);
      send_sample(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
      send_sample(32'sh80000000, 32'sh80000000, 16'hffff);
      send_sample(32'sh80000000, 32'sh7fffffff, 16'h0001);
      send_sample(32'sh7fffffff, 32'sh80000000, 16'h0000);
      send_sample(32'sh00010000, 32'sh00000000, 16'h0041);
      send_sample(32'sh12345678, 32'shedcba987, 16'h8000);
      drain();
   endtask

   task automatic test_noise_extremes();
      write_noise(REG_ANGLE_NOISE, 24'hffffff);
      write_noise(REG_BIAS_NOISE, 24'hffffff);
      write_noise(REG_MEASURE_NOISE, 24'h000001);
      repeat (5) send_sample($urandom, $urandom, 16'hffff);
      drain();
      write_noise(REG_ANGLE_NOISE, 24'h0);
      write_noise(REG_BIAS_NOISE, 24'h0);
      write_noise(REG_MEASURE_NOISE, 24'hffffff);
      repeat (5) send_sample($urandom, $urandom, 16'($urandom));
      send_sample(32'sh00100000, 32'sh0, 16'h0);
      drain();
   endtask

   task automatic test_random(int count);
      logic signed [31:0] base;
      int k;
      for (k = 0; k < count; k++) begin
         if (k % 200 == 0) begin
            drain();
            write_noise(REG_ANGLE_NOISE, 24'($urandom_range(0, 24'hffffff)));
            write_noise(REG_BIAS_NOISE, 24'($urandom_range(0, 24'h3ffff)));
            write_noise(REG_MEASURE_NOISE, 24'($urandom_range(1, 24'hffffff)));
         end
         base = $urandom_range(0, 9) == 0 ? $signed($urandom) :
                $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         if ($urandom_range(0, 9) == 0)
            send_sample($urandom, $urandom, 16'($urandom));
         else
            send_sample(base, $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000,
                        16'($urandom_range(0, 2000)));
      end
      drain();
   endtask

   // receiver holds off while samples keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (6) send_sample($urandom, $urandom, 16'($urandom), 1'b0);
      join
      drain();
   endtask

   initial begin
      reset_predictor();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_noise_extremes();
      test_backpressure();
      test_random(1000);
      if (mismatch_count == 0 && expected_estimates.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end
endmodule
